FILE: rtl/sobel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, register indexes, reset values and beat types of the
// streaming Sobel edge detector.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // default storage limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam int THR_W  = 11;
    localparam int IMGW_W = 12;
    localparam int IMGH_W = 13;

    localparam int RST_THRESHOLD = 90;
    localparam int RST_WIDTH     = 512;
    localparam int RST_HEIGHT    = 512;

    // payload
    localparam int PIX_W  = 8;
    localparam int OCOL_W = 11;
    localparam int OROW_W = 12;
    localparam int CNT_W  = 23;

    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] EDGE_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] EDGE_WHITE = 8'd255;

    // gray = (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
    localparam int RGB_SUM_W       = 10;
    localparam int GRAY_PROD_W     = 20;
    localparam int GRAY_DIV3_MUL   = 683;
    localparam int GRAY_DIV3_SHIFT = 11;

    // gradient arithmetic
    localparam int CSUM_W = 10;
    localparam int GRAD_W = 11;
    localparam int PROD_W = 22;
    localparam int SQ_W   = 20;
    localparam int MAG_W  = 21;
    localparam int THR2_W = 22;

    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] middle;
    } line_pair_t;

    // one window column: top, middle and bottom row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

    typedef struct packed {
        logic [OCOL_W-1:0] ocol;
        logic [OROW_W-1:0] orow;
        logic [CNT_W:0]    cnt_plus1;
    } pix_meta_t;

endpackage
`default_nettype wire

FILE: rtl/sobel_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_line_mem
// Two gray line stores packed in one synchronous memory, one read and one
// write per cycle, with write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module sobel_line_mem #(
    parameter int   DEPTH  = sobel_pkg::DEF_MAX_WIDTH,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  sobel_pkg::line_pair_t wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output sobel_pkg::line_pair_t rd_data
);

    sobel_pkg::line_pair_t mem [DEPTH];

    sobel_pkg::line_pair_t rd_q_reg;
    sobel_pkg::line_pair_t byp_data_reg;
    logic                  byp_hit_reg;
    logic                  byp_hit_next;

    assign byp_hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= byp_hit_next;
        end
    end

    // take the word written in the same cycle as the read
    assign rd_data = byp_hit_reg ? byp_data_reg : rd_q_reg;

endmodule
`default_nettype wire

FILE: rtl/sobel_mag_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_mag_pipe
// Gradient, squared magnitude and threshold compare over a finished 3x3
// window; window, gradient, square and output registers; bubbles collapse.
// ----------------------------------------------------------------------------
module sobel_mag_pipe #(
    parameter int  MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT,
    localparam int WSZ_W      = $clog2(MAX_WIDTH + 1),
    localparam int HSZ_W      = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           win_valid,
    output logic                           win_ready,
    input  sobel_pkg::win_col_t            win_left,
    input  sobel_pkg::win_col_t            win_center,
    input  sobel_pkg::win_col_t            win_right,
    input  sobel_pkg::pix_meta_t           win_meta,
    input  logic [sobel_pkg::THR_W-1:0]    thr,
    input  logic [WSZ_W-1:0]               w_eff,
    input  logic [HSZ_W-1:0]               h_eff,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sobel_pkg::PIX_W-1:0]    edge_value,
    output logic [sobel_pkg::OCOL_W-1:0]   out_col,
    output logic [sobel_pkg::OROW_W-1:0]   out_row,
    output logic                           frame_last
);

    localparam int TOT_W = WSZ_W + HSZ_W;
    localparam int CMP_W = (TOT_W > sobel_pkg::CNT_W + 1) ? TOT_W : sobel_pkg::CNT_W + 1;

    // stage 1: window
    logic                 s1_v_reg;
    sobel_pkg::win_col_t  s1_l_reg, s1_c_reg, s1_r_reg;
    sobel_pkg::pix_meta_t s1_meta_reg;

    // stage 2: gradients
    logic                                s2_v_reg;
    logic signed [sobel_pkg::GRAD_W-1:0] s2_gx_reg, s2_gy_reg;
    logic signed [sobel_pkg::GRAD_W-1:0] s2_gx_next, s2_gy_next;
    sobel_pkg::pix_meta_t                s2_meta_reg;

    // stage 3: squares
    logic                          s3_v_reg;
    logic [sobel_pkg::SQ_W-1:0]    s3_sqx_reg, s3_sqy_reg;
    sobel_pkg::pix_meta_t          s3_meta_reg;
    logic signed [sobel_pkg::PROD_W-1:0] prod_x, prod_y;

    // output register
    logic                          out_v_reg;
    logic [sobel_pkg::PIX_W-1:0]   edge_reg, edge_next;
    logic [sobel_pkg::OCOL_W-1:0]  ocol_reg;
    logic [sobel_pkg::OROW_W-1:0]  orow_reg;
    logic                          last_reg, last_next;
    logic [sobel_pkg::MAG_W-1:0]   mag;

    // settings products, refreshed every cycle
    logic [sobel_pkg::THR2_W-1:0]  thr2_reg;
    logic [TOT_W-1:0]              total_reg;

    logic en1, en2, en3, en4;

    logic [sobel_pkg::CSUM_W-1:0] cs_left, cs_right, rs_top, rs_bot;

    // advance a stage when the one after it is empty or moving
    assign en4       = !out_v_reg || !out_stall;
    assign en3       = !s3_v_reg || en4;
    assign en2       = !s2_v_reg || en3;
    assign en1       = !s1_v_reg || en2;
    assign win_ready = en1;

    always_comb
    begin
        cs_left  = sobel_pkg::CSUM_W'(s1_l_reg.top) + {s1_l_reg.mid, 1'b0}
                 + sobel_pkg::CSUM_W'(s1_l_reg.bot);
        cs_right = sobel_pkg::CSUM_W'(s1_r_reg.top) + {s1_r_reg.mid, 1'b0}
                 + sobel_pkg::CSUM_W'(s1_r_reg.bot);
        rs_top   = sobel_pkg::CSUM_W'(s1_l_reg.top) + {s1_c_reg.top, 1'b0}
                 + sobel_pkg::CSUM_W'(s1_r_reg.top);
        rs_bot   = sobel_pkg::CSUM_W'(s1_l_reg.bot) + {s1_c_reg.bot, 1'b0}
                 + sobel_pkg::CSUM_W'(s1_r_reg.bot);
        s2_gx_next = $signed({1'b0, cs_right}) - $signed({1'b0, cs_left});
        s2_gy_next = $signed({1'b0, rs_bot}) - $signed({1'b0, rs_top});
    end

    assign prod_x = s2_gx_reg * s2_gx_reg;
    assign prod_y = s2_gy_reg * s2_gy_reg;

    always_comb
    begin
        mag       = sobel_pkg::MAG_W'(s3_sqx_reg) + sobel_pkg::MAG_W'(s3_sqy_reg);
        edge_next = (sobel_pkg::THR2_W'(mag) >= thr2_reg) ? sobel_pkg::EDGE_BLACK
                                                           : sobel_pkg::EDGE_WHITE;
        last_next = CMP_W'(s3_meta_reg.cnt_plus1) >= CMP_W'(total_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= win_valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en4)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr2_reg  <= sobel_pkg::THR2_W'(thr) * sobel_pkg::THR2_W'(thr);
        total_reg <= TOT_W'(w_eff) * TOT_W'(h_eff);
        if (en1)
        begin
            s1_l_reg    <= win_left;
            s1_c_reg    <= win_center;
            s1_r_reg    <= win_right;
            s1_meta_reg <= win_meta;
        end
        if (en2)
        begin
            s2_gx_reg   <= s2_gx_next;
            s2_gy_reg   <= s2_gy_next;
            s2_meta_reg <= s1_meta_reg;
        end
        if (en3)
        begin
            s3_sqx_reg  <= prod_x[sobel_pkg::SQ_W-1:0];
            s3_sqy_reg  <= prod_y[sobel_pkg::SQ_W-1:0];
            s3_meta_reg <= s2_meta_reg;
        end
        if (en4)
        begin
            edge_reg <= edge_next;
            ocol_reg <= s3_meta_reg.ocol;
            orow_reg <= s3_meta_reg.orow;
            last_reg <= last_next;
        end
    end

    assign out_valid  = out_v_reg;
    assign edge_value = edge_reg;
    assign out_col    = ocol_reg;
    assign out_row    = orow_reg;
    assign frame_last = last_reg;

endmodule
`default_nettype wire

FILE: rtl/sobel_edge_threshold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector on RGB pixels in raster order, with a
// squared-magnitude threshold and line stores in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  config   | cfg_write           | cfg_index, cfg_data
//  input    | in_valid / in_stall | req_type, red, green, blue
//  output   | out_valid/out_stall | edge_value, out_col, out_row, frame_last
//
//  One item per clock while in_stall is low. An emitting item goes through
//  the pipe stages to the output register; the line store read for the next
//  column is issued in the cycle before, so the memory port sets the pace.
//  Reset clears position, window and pipeline valids; line stores are not
//  cleared. out_stall backs up through the stages; in_stall rises only when
//  every stage holds a result.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [sobel_pkg::PIX_W-1:0]       red,
    input  logic [sobel_pkg::PIX_W-1:0]       green,
    input  logic [sobel_pkg::PIX_W-1:0]       blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sobel_pkg::PIX_W-1:0]       edge_value,
    output logic [sobel_pkg::OCOL_W-1:0]      out_col,
    output logic [sobel_pkg::OROW_W-1:0]      out_row,
    output logic                              frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);

    localparam int W_RST_I = (sobel_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : sobel_pkg::RST_WIDTH;
    localparam int H_RST_I = (sobel_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : sobel_pkg::RST_HEIGHT;
    localparam logic [WSZ_W-1:0] W_RST = WSZ_W'(W_RST_I);
    localparam logic [HSZ_W-1:0] H_RST = HSZ_W'(H_RST_I);

    // settings
    logic [sobel_pkg::THR_W-1:0] thr_reg, thr_next;
    logic [WSZ_W-1:0]            w_reg, w_next;
    logic [HSZ_W-1:0]            h_reg, h_next;
    logic [sobel_pkg::IMGW_W-1:0] cfg_w_raw;
    logic [sobel_pkg::IMGH_W-1:0] cfg_h_raw;
    logic                        cfg_restart;

    // frame position and window
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [sobel_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    sobel_pkg::win_col_t         wmid_reg, wmid_next;
    sobel_pkg::win_col_t         wright_reg, wright_next;

    // accept-cycle datapath
    logic                               accept;
    logic                               pipe_ready;
    sobel_pkg::line_pair_t              line_q;
    sobel_pkg::line_pair_t              line_wr;
    logic [sobel_pkg::RGB_SUM_W-1:0]    rgb_sum;
    logic [sobel_pkg::GRAY_PROD_W-1:0]  gray_prod;
    logic [sobel_pkg::PIX_W-1:0]        gray;
    logic [ROW_W-1:0]                   h_row;
    logic                               col_zero;
    logic                               col_wrap;
    logic                               past_frame;
    logic                               emit;
    sobel_pkg::win_col_t                new_col;
    sobel_pkg::win_col_t                win_right;
    sobel_pkg::pix_meta_t               meta;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !pipe_ready;

    // ---------------- configuration ----------------
    assign cfg_w_raw   = cfg_data[sobel_pkg::IMGW_W-1:0];
    assign cfg_h_raw   = cfg_data[sobel_pkg::IMGH_W-1:0];
    assign cfg_restart = cfg_write && ((cfg_index == sobel_pkg::REG_WIDTH) ||
                                       (cfg_index == sobel_pkg::REG_HEIGHT));

    always_comb
    begin
        thr_next = thr_reg;
        w_next   = w_reg;
        h_next   = h_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sobel_pkg::REG_THRESHOLD:
                begin
                    thr_next = cfg_data[sobel_pkg::THR_W-1:0];
                end
                sobel_pkg::REG_WIDTH:
                begin
                    // clamp to 1..MAX_WIDTH
                    if (cfg_w_raw == '0)
                        w_next = WSZ_W'(1);
                    else if (cfg_w_raw > MAX_WIDTH)
                        w_next = WSZ_W'(MAX_WIDTH);
                    else
                        w_next = WSZ_W'(cfg_w_raw);
                end
                sobel_pkg::REG_HEIGHT:
                begin
                    if (cfg_h_raw == '0)
                        h_next = HSZ_W'(1);
                    else if (cfg_h_raw > MAX_HEIGHT)
                        h_next = HSZ_W'(MAX_HEIGHT);
                    else
                        h_next = HSZ_W'(cfg_h_raw);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- pixel slot ----------------
    assign rgb_sum   = sobel_pkg::RGB_SUM_W'(red) + sobel_pkg::RGB_SUM_W'(green)
                     + sobel_pkg::RGB_SUM_W'(blue);
    assign gray_prod = sobel_pkg::GRAY_PROD_W'(rgb_sum)
                     * sobel_pkg::GRAY_PROD_W'(sobel_pkg::GRAY_DIV3_MUL);
    assign gray      = gray_prod[sobel_pkg::GRAY_DIV3_SHIFT +: sobel_pkg::PIX_W];

    assign h_row      = ROW_W'(h_reg);
    assign col_zero   = (col_reg == '0);
    assign col_wrap   = (WSZ_W'(col_reg) + 1'b1) == w_reg;
    assign past_frame = row_reg > h_row;
    assign emit       = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && !col_zero);

    always_comb
    begin
        // mask rows outside the frame to zero
        new_col.top = (row_reg >= ROW_W'(2)) ? line_q.above : '0;
        new_col.mid = ((row_reg != '0) && (row_reg <= h_row)) ? line_q.middle : '0;
        new_col.bot = ((row_reg < h_row) && (req_type != sobel_pkg::REQ_FLUSH)) ? gray : '0;
        // first column closes the previous row: right neighbor is outside
        win_right   = col_zero ? '0 : new_col;

        meta.ocol      = col_zero ? sobel_pkg::OCOL_W'(w_reg - 1'b1)
                                  : sobel_pkg::OCOL_W'(col_reg - 1'b1);
        meta.orow      = col_zero ? sobel_pkg::OROW_W'(row_reg - 2'd2)
                                  : sobel_pkg::OROW_W'(row_reg - 1'b1);
        meta.cnt_plus1 = (sobel_pkg::CNT_W + 1)'(cnt_reg) + 1'b1;

        line_wr.above  = line_q.middle;
        line_wr.middle = new_col.bot;
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        wmid_next   = wmid_reg;
        wright_next = wright_reg;
        if (cfg_restart)
        begin
            col_next    = '0;
            row_next    = '0;
            cnt_next    = '0;
            wmid_next   = '0;
            wright_next = '0;
        end
        else if (accept)
        begin
            wmid_next   = col_zero ? '0 : wright_reg;
            wright_next = new_col;
            if (emit)
                cnt_next = cnt_reg + 1'b1;
            if (past_frame)
            begin
                // last flush slot: restart the frame
                col_next    = '0;
                row_next    = '0;
                cnt_next    = '0;
                wmid_next   = '0;
                wright_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= sobel_pkg::THR_W'(sobel_pkg::RST_THRESHOLD);
            w_reg      <= W_RST;
            h_reg      <= H_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            wmid_reg   <= '0;
            wright_reg <= '0;
        end
        else
        begin
            thr_reg    <= thr_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            wmid_reg   <= wmid_next;
            wright_reg <= wright_next;
        end
    end

    // read ahead at the next position so the data lines up with col_reg
    sobel_line_mem #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (line_wr),
        .rd_addr (col_next),
        .rd_data (line_q)
    );

    sobel_mag_pipe #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_mag_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (accept && emit),
        .win_ready  (pipe_ready),
        .win_left   (wmid_reg),
        .win_center (wright_reg),
        .win_right  (win_right),
        .win_meta   (meta),
        .thr        (thr_reg),
        .w_eff      (w_reg),
        .h_eff      (h_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_value (edge_value),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

endmodule
`default_nettype wire

FILE: tb/sobel_edge_threshold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// Self-checking bench for the streaming Sobel edge detector. A predictor
// follows every accepted pixel and flush beat: it keeps its own line stores,
// 3x3 window and frame position, and queues the edge result it expects. The
// receiver checks each output beat against the oldest queued result. The
// tests cover reset values, a hand-built frame, threshold extremes, zero
// sizes, restarts in the middle of a frame and random traffic, while the
// sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;

    localparam int MAX_W = sobel_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H = sobel_pkg::DEF_MAX_HEIGHT;
    localparam logic REQ_PIXEL = ~sobel_pkg::REQ_FLUSH;
    localparam logic [sobel_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int RANDOM_BEATS  = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [sobel_pkg::PIX_W-1:0]  shade;
        logic [sobel_pkg::OCOL_W-1:0] col;
        logic [sobel_pkg::OROW_W-1:0] row;
        logic                         last;
    } edge_pixel_t;

    typedef enum {FRAME_CLEAN, FRAME_NOISY, FRAME_CUT} frame_kind_t;

    logic                             clk;
    logic                             rst_n      = 1'b0;
    logic                             cfg_write  = 1'b0;
    logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                             in_valid   = 1'b0;
    logic                             in_stall;
    logic                             req_type   = REQ_PIXEL;
    logic [sobel_pkg::PIX_W-1:0]      red        = '0;
    logic [sobel_pkg::PIX_W-1:0]      green      = '0;
    logic [sobel_pkg::PIX_W-1:0]      blue       = '0;
    logic                             out_valid;
    logic                             out_stall  = 1'b0;
    logic [sobel_pkg::PIX_W-1:0]      edge_value;
    logic [sobel_pkg::OCOL_W-1:0]     out_col;
    logic [sobel_pkg::OROW_W-1:0]     out_row;
    logic                             frame_last;

    sobel_edge_threshold i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_value (edge_value),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

    // predictor state
    logic [sobel_pkg::PIX_W-1:0] line_above  [MAX_W];
    logic [sobel_pkg::PIX_W-1:0] line_middle [MAX_W];
    logic [sobel_pkg::PIX_W-1:0] gray_win    [9];
    int unsigned col_pos, row_pos, emitted;
    int unsigned thr_reg, width_reg, height_reg;
    bit frame_wrapped;
    edge_pixel_t pending_edges [$];

    // bookkeeping
    int unsigned beats_sent   = 0;
    int unsigned flush_beats  = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen  = 0;
    int unsigned cfg_writes   = 0;
    int unsigned mismatches   = 0;
    int unsigned widest       = 0;
    int unsigned tallest      = 0;
    int unsigned burst_left   = 0;
    int unsigned frame_tone   = 0;
    bit          sender_steady = 1'b0;
    bit          rx_open       = 1'b0;
    int unsigned stall_mode    = 0;
    int unsigned stall_left    = 0;
    int unsigned stall_tick    = 0;
    int          cycles        = 0;
    edge_pixel_t seen_edge, want_edge;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int tap_sum(logic [sobel_pkg::PIX_W-1:0] a,
                                   logic [sobel_pkg::PIX_W-1:0] b,
                                   logic [sobel_pkg::PIX_W-1:0] c);
        return int'(a) + 2 * int'(b) + int'(c);
    endfunction

    task automatic restart_frame_model();
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
        gray_win = '{default: '0};
    endtask

    task automatic reset_model();
        foreach (line_above[k])
        begin
            line_above[k]  = '0;
            line_middle[k] = '0;
        end
        thr_reg    = sobel_pkg::RST_THRESHOLD;
        width_reg  = sobel_pkg::RST_WIDTH;
        height_reg = sobel_pkg::RST_HEIGHT;
        restart_frame_model();
    endtask

    task automatic apply_register(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sobel_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            sobel_pkg::REG_THRESHOLD: thr_reg = 32'(data[sobel_pkg::THR_W-1:0]);
            sobel_pkg::REG_WIDTH:
            begin
                width_reg = 32'(data[sobel_pkg::IMGW_W-1:0]);
                restart_frame_model();
            end
            sobel_pkg::REG_HEIGHT:
            begin
                height_reg = 32'(data[sobel_pkg::IMGH_W-1:0]);
                restart_frame_model();
            end
            default: ;
        endcase
    endtask

    // Advance the window by one beat and queue the edge pixel it completes.
    task automatic compute_edge_result(input logic req,
                                       input logic [sobel_pkg::PIX_W-1:0] r,
                                       input logic [sobel_pkg::PIX_W-1:0] g,
                                       input logic [sobel_pkg::PIX_W-1:0] b);
        int unsigned w, h, c, row, gray, ocol, orow, mag2, thr2;
        int gx, gy;
        logic [sobel_pkg::PIX_W-1:0] top, mid, bot;
        logic [sobel_pkg::PIX_W-1:0] nb [9];
        bit emit;
        edge_pixel_t e;
        begin
            w    = clamp_dim(width_reg, MAX_W);
            h    = clamp_dim(height_reg, MAX_H);
            c    = (col_pos >= w) ? 0 : col_pos;
            row  = row_pos;
            gray = (32'(r) + 32'(g) + 32'(b)) / 3;
            top  = (row >= 2) ? line_above[c] : '0;
            mid  = (row >= 1 && row <= h) ? line_middle[c] : '0;
            bot  = (row < h && req != sobel_pkg::REQ_FLUSH) ? gray[sobel_pkg::PIX_W-1:0] : '0;
            emit = (row >= 2) || (row == 1 && c >= 1);

            if (c == 0)
            begin
                // close the previous row: right neighbors lie off the frame
                for (int k = 0; k < 3; k++)
                begin
                    nb[3*k]   = gray_win[3*k+1];
                    nb[3*k+1] = gray_win[3*k+2];
                    nb[3*k+2] = '0;
                end
                ocol = w - 1;
                orow = (row >= 2) ? row - 2 : 0;
                gray_win = '{default: '0};
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    gray_win[3*k]   = gray_win[3*k+1];
                    gray_win[3*k+1] = gray_win[3*k+2];
                end
                ocol = c - 1;
                orow = row - 1;
            end
            gray_win[2] = top;
            gray_win[5] = mid;
            gray_win[8] = bot;
            if (c != 0)
                nb = gray_win;

            line_above[c]  = line_middle[c];
            line_middle[c] = bot;

            if (emit)
            begin
                gx   = tap_sum(nb[2], nb[5], nb[8]) - tap_sum(nb[0], nb[3], nb[6]);
                gy   = tap_sum(nb[6], nb[7], nb[8]) - tap_sum(nb[0], nb[1], nb[2]);
                mag2 = gx * gx + gy * gy;
                thr2 = thr_reg * thr_reg;
                e.shade = (mag2 >= thr2) ? sobel_pkg::EDGE_BLACK : sobel_pkg::EDGE_WHITE;
                e.col   = ocol[sobel_pkg::OCOL_W-1:0];
                e.row   = orow[sobel_pkg::OROW_W-1:0];
                e.last  = (emitted + 1 >= w * h);
                emitted = (emitted + 1) % (1 << sobel_pkg::CNT_W);
                pending_edges.push_back(e);
            end

            if (row >= h + 1)
            begin
                restart_frame_model();
                frame_wrapped = 1'b1;
            end
            else
            begin
                c++;
                if (c >= w)
                begin
                    c = 0;
                    row++;
                end
                col_pos = c;
                row_pos = row;
            end
        end
    endtask

    function automatic logic [3*sobel_pkg::PIX_W-1:0] pick_colour();
        logic [sobel_pkg::PIX_W-1:0] ch [3];
        int level;
        begin
            case ($urandom_range(0, 5))
                0, 1:
                    foreach (ch[k])
                        ch[k] = 8'($urandom_range(0, 255));
                2:
                    foreach (ch[k])
                        ch[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:
                    // flat area: the frame's tone plus a little noise
                    foreach (ch[k])
                    begin
                        level = int'(frame_tone) + int'($urandom_range(0, 16)) - 8;
                        ch[k] = (level < 0) ? 8'h00 : (level > 255) ? 8'hFF : level[7:0];
                    end
            endcase
            return {ch[0], ch[1], ch[2]};
        end
    endfunction

    // Send one beat; hold it until it is taken.
    task automatic send_item(input logic req, input logic [3*sobel_pkg::PIX_W-1:0] rgb);
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (!sender_steady && $urandom_range(0, 3) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            req_type <= req;
            red      <= rgb[23:16];
            green    <= rgb[15:8];
            blue     <= rgb[7:0];
            do
                @(posedge clk);
            while (in_stall);
            compute_edge_result(req, rgb[23:16], rgb[15:8], rgb[7:0]);
            beats_sent++;
            if (req == sobel_pkg::REQ_FLUSH)
                flush_beats++;
        end
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_edges.size() != 0);
    endtask

    // Drain, then hold the receiver open with input idle so the pipeline clears.
    task automatic settle_idle();
        pause_until_drained();
        rx_open = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        rx_open = 1'b0;
    endtask

    task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sobel_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Feed beats in the roles the frame position asks for, up to the frame end.
    task automatic send_frame(input frame_kind_t kind, input int unsigned cut_after);
        int unsigned w, h, sent;
        logic req;
        begin
            w = clamp_dim(width_reg, MAX_W);
            h = clamp_dim(height_reg, MAX_H);
            if (w > widest)
                widest = w;
            if (h > tallest)
                tallest = h;
            frame_wrapped = 1'b0;
            frame_tone = $urandom_range(0, 255);
            sent = 0;
            while (!frame_wrapped && !(kind == FRAME_CUT && sent >= cut_after))
            begin
                req = (row_pos < h) ? REQ_PIXEL : sobel_pkg::REQ_FLUSH;
                if (kind == FRAME_NOISY && $urandom_range(0, 5) == 0)
                    req = ~req;
                if ($urandom_range(0, 299) == 0)
                    pause_until_drained();
                send_item(req, pick_colour());
                sent++;
            end
        end
    endtask

    task automatic test_reset_values();
        send_frame(FRAME_CUT, sobel_pkg::RST_WIDTH + 4);
        settle_idle();
    endtask

    // 4x3 frame: channel extremes, rounding of the gray divide, a flush in a
    // pixel slot and a colored pixel in a flush slot.
    task automatic test_directed_frame();
        logic [3*sobel_pkg::PIX_W:0] script [17] = '{
            {REQ_PIXEL, 8'd255, 8'd255, 8'd255}, {REQ_PIXEL, 8'd0,   8'd0,   8'd0},
            {REQ_PIXEL, 8'd255, 8'd255, 8'd254}, {REQ_PIXEL, 8'd1,   8'd1,   8'd0},
            {sobel_pkg::REQ_FLUSH, 8'd255, 8'd255, 8'd255},
            {REQ_PIXEL, 8'd255, 8'd0,   8'd0},
            {REQ_PIXEL, 8'd0,   8'd255, 8'd0},   {REQ_PIXEL, 8'd0,   8'd0,   8'd255},
            {REQ_PIXEL, 8'd128, 8'd128, 8'd128}, {REQ_PIXEL, 8'd255, 8'd255, 8'd255},
            {REQ_PIXEL, 8'd0,   8'd0,   8'd0},   {REQ_PIXEL, 8'd200, 8'd100, 8'd50},
            {REQ_PIXEL, 8'd255, 8'd255, 8'd255},
            {sobel_pkg::REQ_FLUSH, 8'd0, 8'd0, 8'd0},
            {sobel_pkg::REQ_FLUSH, 8'd0, 8'd0, 8'd0},
            {sobel_pkg::REQ_FLUSH, 8'd0, 8'd0, 8'd0},
            {sobel_pkg::REQ_FLUSH, 8'd0, 8'd0, 8'd0}
        };
        write_reg(sobel_pkg::REG_WIDTH, 13'd4);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd3);
        write_reg(sobel_pkg::REG_THRESHOLD, 13'd90);
        foreach (script[k])
            send_item(script[k][3*sobel_pkg::PIX_W], script[k][3*sobel_pkg::PIX_W-1:0]);
        settle_idle();
    endtask

    // Upper data bits beyond the register width must be dropped.
    task automatic test_thresholds();
        logic [sobel_pkg::CFG_DATA_W-1:0] levels [4] = '{13'h1800, 13'd1, 13'd1500, 13'h1FFF};
        write_reg(sobel_pkg::REG_WIDTH, 13'd4);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd3);
        foreach (levels[k])
        begin
            write_reg(sobel_pkg::REG_THRESHOLD, levels[k]);
            send_frame(FRAME_CLEAN, 0);
            settle_idle();
        end
    endtask

    task automatic test_threshold_mid_frame();
        write_reg(sobel_pkg::REG_WIDTH, 13'd6);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd5);
        write_reg(sobel_pkg::REG_THRESHOLD, 13'd60);
        send_frame(FRAME_CUT, 20);
        settle_idle();
        write_reg(sobel_pkg::REG_THRESHOLD, 13'd200);
        send_frame(FRAME_CLEAN, 0);
        settle_idle();
    endtask

    task automatic test_size_restart();
        write_reg(sobel_pkg::REG_WIDTH, 13'd7);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd4);
        send_frame(FRAME_CUT, 17);
        settle_idle();
        write_reg(sobel_pkg::REG_WIDTH, 13'd3);
        send_frame(FRAME_CUT, 5);
        settle_idle();
        write_reg(sobel_pkg::REG_HEIGHT, 13'd2);
        // back-to-back frames with no write in between
        repeat (3) send_frame(FRAME_CLEAN, 0);
        settle_idle();
    endtask

    task automatic test_unmapped_register();
        send_frame(FRAME_CUT, 4);
        settle_idle();
        write_reg(REG_UNMAPPED, 13'h1FFF);
        write_reg(REG_UNMAPPED, 13'h0000);
        send_frame(FRAME_CLEAN, 0);
        settle_idle();
    endtask

    task automatic test_size_clamps();
        write_reg(sobel_pkg::REG_WIDTH, 13'd0);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd0);
        send_frame(FRAME_CLEAN, 0);
        settle_idle();
        write_reg(sobel_pkg::REG_HEIGHT, 13'd4);
        send_frame(FRAME_CLEAN, 0);
        settle_idle();
        write_reg(sobel_pkg::REG_WIDTH, 13'd5);
        write_reg(sobel_pkg::REG_HEIGHT, 13'd0);
        send_frame(FRAME_CLEAN, 0);
        settle_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned start, pick;
        logic [sobel_pkg::CFG_DATA_W-1:0] data;
        frame_kind_t kind;
        begin
            start = beats_sent;
            while (beats_sent - start < RANDOM_BEATS)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    settle_idle();
                    if ($urandom_range(0, 1))
                    begin
                        case ($urandom_range(0, 5))
                            0: data = sobel_pkg::CFG_DATA_W'($urandom_range(0, 8191));
                            1: data = sobel_pkg::CFG_DATA_W'($urandom_range(0, 1500));
                            default: data = sobel_pkg::CFG_DATA_W'($urandom_range(20, 400));
                        endcase
                        write_reg(sobel_pkg::REG_THRESHOLD, data);
                    end
                    if ($urandom_range(0, 7) == 0)
                        write_reg(REG_UNMAPPED, sobel_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                    case ($urandom_range(0, 9))
                        0: data = 13'd0;
                        1: data = 13'h1000 | sobel_pkg::CFG_DATA_W'($urandom_range(1, 12));
                        2: data = sobel_pkg::CFG_DATA_W'($urandom_range(13, 40));
                        default: data = sobel_pkg::CFG_DATA_W'($urandom_range(1, 12));
                    endcase
                    write_reg(sobel_pkg::REG_WIDTH, data);
                    data = ($urandom_range(0, 9) == 0) ? 13'd0
                                                       : sobel_pkg::CFG_DATA_W'($urandom_range(1, 8));
                    write_reg(sobel_pkg::REG_HEIGHT, data);
                end
                sender_steady = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 19);
                kind = (pick < 2) ? FRAME_CUT : (pick < 5) ? FRAME_NOISY : FRAME_CLEAN;
                send_frame(kind, $urandom_range(1, 40));
            end
            sender_steady = 1'b0;
            settle_idle();
        end
    endtask

    // receiver: pick one of four stall patterns, each held for a random run
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end
        else
            stall_left--;
        stall_tick++;
        if (rx_open || stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else if (stall_mode == 2)
            out_stall <= (stall_tick % 3 != 0);
        else
            out_stall <= 1'($urandom_range(0, 1));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_edge = {edge_value, out_col, out_row, frame_last};
            results_seen++;
            if (frame_last)
                frames_seen++;
            if (pending_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result value %0d col %0d row %0d last %0b",
                             $realtime, seen_edge.shade, seen_edge.col, seen_edge.row,
                             seen_edge.last);
            end
            else
            begin
                want_edge = pending_edges.pop_front();
                if (seen_edge.shade !== want_edge.shade || seen_edge.col !== want_edge.col ||
                    seen_edge.row !== want_edge.row || seen_edge.last !== want_edge.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: expected value %0d col %0d row %0d last %0b,",
                                  " got value %0d col %0d row %0d last %0b"},
                                 $realtime, want_edge.shade, want_edge.col, want_edge.row,
                                 want_edge.last, seen_edge.shade, seen_edge.col,
                                 seen_edge.row, seen_edge.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_edges.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_frame();
        test_thresholds();
        test_threshold_mid_frame();
        test_size_restart();
        test_unmapped_register();
        test_size_clamps();
        test_random_traffic();

        $display("Sent %0d input beats (%0d flush), checked %0d results, %0d frames closed.",
                 beats_sent, flush_beats, results_seen, frames_seen);
        $display("%0d register writes, frames up to %0d wide and %0d high, %0d mismatches.",
                 cfg_writes, widest, tallest, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sobel_edge_threshold.f
rtl/sobel_pkg.sv
rtl/sobel_line_mem.sv
rtl/sobel_mag_pipe.sv
rtl/sobel_edge_threshold.sv
tb/sobel_edge_threshold_tb.sv
